[rtl/fwq_pkg.sv]
// Shared types, codes and constants for the futex wait-queue table.
`timescale 1ns / 1ps

package fwq_pkg;

  // Field widths
  localparam int FUNC_W   = 2;
  localparam int PROC_W   = 8;
  localparam int ADDR_W   = 48;
  localparam int CNT_W    = 7;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  // Table sizing
  localparam int DEF_SLOTS  = 64;
  localparam int WAKE_LIMIT = 64;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_WAIT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_WAKE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_DROP = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVAL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // One result beat
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                has_woken;
    logic [PROC_W-1:0]   woken_proc;
    logic [CNT_W-1:0]    woken_total;
    logic                last;
  } res_t;

  // Result handed from the sequencer to the output register
  typedef struct packed {
    logic valid;
    res_t res;
  } push_t;

  // Build a final result that carries a status and nothing else
  function automatic res_t mk_res(input logic [STATUS_W-1:0] status);
    res_t r;
    r        = '0;
    r.status = status;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

[rtl/fwq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module fwq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/fwq_ctrl.sv]
// Slot scan sequencer: valid bits, shared compare unit and result staging.
`timescale 1ns / 1ps

module fwq_ctrl #(
  parameter int SLOTS = fwq_pkg::DEF_SLOTS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [fwq_pkg::FUNC_W-1:0]       in_func,
  input  logic [fwq_pkg::PROC_W-1:0]       in_proc_id,
  input  logic [fwq_pkg::ADDR_W-1:0]       in_wait_address,
  input  logic [fwq_pkg::CNT_W-1:0]        in_wake_count,
  // slot store
  output logic                             ram_wr_en,
  output logic [$clog2(SLOTS)-1:0]         ram_wr_addr,
  output logic [fwq_pkg::PROC_W+fwq_pkg::ADDR_W-1:0] ram_wr_data,
  output logic [$clog2(SLOTS)-1:0]         ram_rd_addr,
  input  logic [fwq_pkg::PROC_W+fwq_pkg::ADDR_W-1:0] ram_rd_data,
  // output register
  input  logic                             out_free,
  output fwq_pkg::push_t                   push
);

  localparam int IDX_W = $clog2(SLOTS);

  fwq_pkg::state_t st_r, st_nxt;

  logic [SLOTS-1:0]                 valid_r, valid_nxt;
  logic [IDX_W-1:0]                 idx_r, idx_nxt;
  logic [fwq_pkg::CNT_W-1:0]        woke_r, woke_nxt;
  logic                             have_pend_r, have_pend_nxt;
  fwq_pkg::res_t                    pend_r, pend_nxt;

  logic [fwq_pkg::FUNC_W-1:0]       func_r;
  logic [fwq_pkg::PROC_W-1:0]       pid_r;
  logic [fwq_pkg::ADDR_W-1:0]       addr_r;
  logic [fwq_pkg::CNT_W-1:0]        cnt_r;

  logic                             in_take;
  logic [fwq_pkg::CNT_W-1:0]        cnt_sat;
  logic [fwq_pkg::PROC_W-1:0]       ram_proc;
  logic [fwq_pkg::ADDR_W-1:0]       ram_addr;
  logic                             cur_valid;
  logic                             at_end;
  logic [fwq_pkg::CNT_W-1:0]        woke_inc;
  logic                             wake_hit;
  logic                             wake_hold;
  logic                             wake_done;
  logic                             drop_hit;
  logic [IDX_W+fwq_pkg::SLOT_W-1:0] idx_wide;
  logic [fwq_pkg::SLOT_W-1:0]       slot6;
  fwq_pkg::res_t                    hit_res;

  // Accept only between items
  assign in_stall = (st_r != fwq_pkg::S_IDLE);
  assign in_take  = in_valid && (st_r == fwq_pkg::S_IDLE);
  assign cnt_sat  = (in_wake_count > fwq_pkg::CNT_W'(fwq_pkg::WAKE_LIMIT)) ?
                    fwq_pkg::CNT_W'(fwq_pkg::WAKE_LIMIT) : in_wake_count;

  // Compare unit on the slot read back this cycle
  assign ram_proc  = ram_rd_data[fwq_pkg::PROC_W+fwq_pkg::ADDR_W-1:fwq_pkg::ADDR_W];
  assign ram_addr  = ram_rd_data[fwq_pkg::ADDR_W-1:0];
  assign cur_valid = valid_r[idx_r];
  assign at_end    = (idx_r == IDX_W'(SLOTS - 1));
  assign woke_inc  = woke_r + fwq_pkg::CNT_W'(1);
  assign wake_hit  = cur_valid && (ram_addr == addr_r);
  assign wake_hold = wake_hit && have_pend_r && !out_free;
  assign wake_done = wake_hit && (woke_inc == cnt_r);
  assign drop_hit  = cur_valid && (ram_proc == pid_r);
  assign idx_wide  = (IDX_W + fwq_pkg::SLOT_W)'(idx_r);
  assign slot6     = idx_wide[fwq_pkg::SLOT_W-1:0];

  // Result for a woken slot
  always_comb begin
    hit_res             = '0;
    hit_res.status      = fwq_pkg::ST_OK;
    hit_res.slot_index  = slot6;
    hit_res.has_woken   = 1'b1;
    hit_res.woken_proc  = ram_proc;
    hit_res.woken_total = woke_inc;
    hit_res.last        = wake_done || at_end;
  end

  // Next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      fwq_pkg::S_IDLE: begin
        if (in_take) begin
          case (in_func)
            fwq_pkg::FN_WAIT: begin
              if (in_proc_id == '0 || in_wait_address == '0) begin
                st_nxt = fwq_pkg::S_EMIT;
              end else begin
                st_nxt = fwq_pkg::S_SCAN;
              end
            end
            fwq_pkg::FN_WAKE: begin
              if (in_wait_address == '0 || cnt_sat == '0) begin
                st_nxt = fwq_pkg::S_EMIT;
              end else begin
                st_nxt = fwq_pkg::S_SCAN;
              end
            end
            fwq_pkg::FN_DROP: begin
              if (in_proc_id == '0) begin
                st_nxt = fwq_pkg::S_EMIT;
              end else begin
                st_nxt = fwq_pkg::S_SCAN;
              end
            end
            default: st_nxt = fwq_pkg::S_EMIT;
          endcase
        end
      end
      fwq_pkg::S_SCAN: begin
        case (func_r)
          fwq_pkg::FN_WAIT: begin
            if (!cur_valid || at_end) begin
              st_nxt = fwq_pkg::S_EMIT;
            end
          end
          fwq_pkg::FN_WAKE: begin
            if (!wake_hold && (wake_done || at_end)) begin
              st_nxt = fwq_pkg::S_EMIT;
            end
          end
          fwq_pkg::FN_DROP: begin
            if (at_end) begin
              st_nxt = fwq_pkg::S_EMIT;
            end
          end
          default: st_nxt = fwq_pkg::S_EMIT;
        endcase
      end
      fwq_pkg::S_EMIT: begin
        if (out_free) begin
          st_nxt = fwq_pkg::S_IDLE;
        end
      end
      default: st_nxt = fwq_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    valid_nxt     = valid_r;
    idx_nxt       = idx_r;
    woke_nxt      = woke_r;
    have_pend_nxt = have_pend_r;
    pend_nxt      = pend_r;
    push          = '0;
    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r;
    ram_wr_data   = {pid_r, addr_r};

    case (st_r)
      fwq_pkg::S_IDLE: begin
        idx_nxt       = '0;
        woke_nxt      = '0;
        have_pend_nxt = 1'b0;
        if (in_take) begin
          case (in_func)
            fwq_pkg::FN_WAIT: pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_INVAL);
            fwq_pkg::FN_WAKE: pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_OK);
            fwq_pkg::FN_DROP: pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_OK);
            default:          pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_INVAL);
          endcase
        end
      end
      fwq_pkg::S_SCAN: begin
        case (func_r)
          fwq_pkg::FN_WAIT: begin
            // Claim the first free slot
            if (!cur_valid) begin
              ram_wr_en          = 1'b1;
              valid_nxt[idx_r]   = 1'b1;
              pend_nxt           = fwq_pkg::mk_res(fwq_pkg::ST_OK);
              pend_nxt.slot_index = slot6;
            end else if (at_end) begin
              pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_FULL);
            end
          end
          fwq_pkg::FN_WAKE: begin
            // Free a match; release the previous one now that it is not last
            if (wake_hit && !wake_hold) begin
              push.valid       = have_pend_r;
              push.res         = pend_r;
              valid_nxt[idx_r] = 1'b0;
              woke_nxt         = woke_inc;
              pend_nxt         = hit_res;
              have_pend_nxt    = 1'b1;
            end else if (!wake_hit && at_end) begin
              if (have_pend_r) begin
                pend_nxt.last = 1'b1;
              end else begin
                pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_OK);
              end
            end
          end
          fwq_pkg::FN_DROP: begin
            if (drop_hit) begin
              valid_nxt[idx_r] = 1'b0;
            end
            if (at_end) begin
              pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_OK);
            end
          end
          default: pend_nxt = fwq_pkg::mk_res(fwq_pkg::ST_INVAL);
        endcase
        // Advance the scan unless holding or leaving
        if (st_nxt == fwq_pkg::S_SCAN && !wake_hold) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      fwq_pkg::S_EMIT: begin
        if (out_free) begin
          push.valid    = 1'b1;
          push.res      = pend_r;
          have_pend_nxt = 1'b0;
        end
      end
      default: ;
    endcase
  end

  // Read the slot the scan looks at next cycle
  assign ram_rd_addr = idx_nxt;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= fwq_pkg::S_IDLE;
      valid_r     <= '0;
      idx_r       <= '0;
      woke_r      <= '0;
      have_pend_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      valid_r     <= valid_nxt;
      idx_r       <= idx_nxt;
      woke_r      <= woke_nxt;
      have_pend_r <= have_pend_nxt;
    end
  end

  // Item capture and staged result
  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (in_take) begin
      func_r <= in_func;
      pid_r  <= in_proc_id;
      addr_r <= in_wait_address;
      cnt_r  <= cnt_sat;
    end
  end

endmodule

[rtl/futex_wait_queue_table_core.sv]
// Top level of the futex wait-queue table: slot store, sequencer, output register.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------------
//   in_     | input     | in_valid/in_stall  | func, proc_id, wait_address, wake_count
//   out_    | output    | out_valid/out_stall| status, slot_index, has_woken, woken_proc,
//           |           |                    | woken_total, last
//
// An item scans the slots one per cycle through the single slot-store read port,
// held while a wake match waits for the output register. A wait stops at the first
// free slot, a wake at its count, any scan at the last slot; no-scan items skip it.
// out_stall stretches an item only while a beat waits for the output register.
// Reset clears the valid flops at once, so no clearing pass runs; in_stall is high
// from acceptance until the final beat of an item enters the output register.
`timescale 1ns / 1ps

module futex_wait_queue_table_core #(
  parameter int SLOTS = fwq_pkg::DEF_SLOTS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fwq_pkg::FUNC_W-1:0]    in_func,
  input  logic [fwq_pkg::PROC_W-1:0]    in_proc_id,
  input  logic [fwq_pkg::ADDR_W-1:0]    in_wait_address,
  input  logic [fwq_pkg::CNT_W-1:0]     in_wake_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fwq_pkg::STATUS_W-1:0]  out_status,
  output logic [fwq_pkg::SLOT_W-1:0]    out_slot_index,
  output logic                          out_has_woken,
  output logic [fwq_pkg::PROC_W-1:0]    out_woken_proc,
  output logic [fwq_pkg::CNT_W-1:0]     out_woken_total,
  output logic                          out_last
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int DATA_W = fwq_pkg::PROC_W + fwq_pkg::ADDR_W;

  logic              ram_wr_en;
  logic [IDX_W-1:0]  ram_wr_addr;
  logic [DATA_W-1:0] ram_wr_data;
  logic [IDX_W-1:0]  ram_rd_addr;
  logic [DATA_W-1:0] ram_rd_data;
  logic              out_free;
  fwq_pkg::push_t    push;

  logic              out_valid_r, out_valid_nxt;
  fwq_pkg::res_t     out_res_r;

  // Slot store: process id and wait address per slot
  fwq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Scan sequencer
  fwq_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_proc_id      (in_proc_id),
    .in_wait_address (in_wait_address),
    .in_wake_count   (in_wake_count),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data),
    .out_free        (out_free),
    .push            (push)
  );

  // Output register: load a new beat or drop the taken one
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (push.valid) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_res_r <= push.res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_slot_index  = out_res_r.slot_index;
  assign out_has_woken   = out_res_r.has_woken;
  assign out_woken_proc  = out_res_r.woken_proc;
  assign out_woken_total = out_res_r.woken_total;
  assign out_last        = out_res_r.last;

endmodule

[test/tb_futex_wait_queue_table_core.sv]
// Testbench for the futex wait-queue table core: directed, table-full and random traffic.
`timescale 1ns / 1ps

module tb_futex_wait_queue_table_core;
  import fwq_pkg::*;

  localparam int                TB_SLOTS    = DEF_SLOTS;
  localparam int                IDLE_LIMIT  = 4000;
  localparam int                HOLD_CYCLES = 300;
  localparam logic [FUNC_W-1:0] FN_UNDEF    = 2'd3;
  localparam logic [ADDR_W-1:0] ADDR_TOP    = 48'hFFFF_FFFF_FFFF;

  logic                clk             = 1'b0;
  logic                rst_n           = 1'b0;
  logic                in_valid        = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func         = '0;
  logic [PROC_W-1:0]   in_proc_id      = '0;
  logic [ADDR_W-1:0]   in_wait_address = '0;
  logic [CNT_W-1:0]    in_wake_count   = '0;
  logic                out_valid;
  logic                out_stall       = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot_index;
  logic                out_has_woken;
  logic [PROC_W-1:0]   out_woken_proc;
  logic [CNT_W-1:0]    out_woken_total;
  logic                out_last;

  // Shadow copy of the waiter table
  logic                table_valid [TB_SLOTS];
  logic [PROC_W-1:0]   table_proc  [TB_SLOTS];
  logic [ADDR_W-1:0]   table_addr  [TB_SLOTS];

  res_t                pending_results [$];
  int                  errors    = 0;
  bit                  calm      = 1'b0;
  int                  hold_req  = 0;
  int                  hold_left = 0;

  futex_wait_queue_table_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_proc_id      (in_proc_id),
    .in_wait_address (in_wait_address),
    .in_wake_count   (in_wake_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index),
    .out_has_woken   (out_has_woken),
    .out_woken_proc  (out_woken_proc),
    .out_woken_total (out_woken_total),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // Apply one request to the shadow table and queue the beats it should produce
  function automatic void apply_table_op(input logic [FUNC_W-1:0] fn,
                                         input logic [PROC_W-1:0] pid,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [CNT_W-1:0]  cnt);
    res_t r;
    res_t w;
    res_t burst [$];
    int   lim;
    int   woke;
    r      = '0;
    r.last = 1'b1;
    case (fn)
      FN_WAIT: begin
        if (pid == '0 || addr == '0) begin
          r.status = ST_INVAL;
        end else begin
          // take the lowest free slot, else report full
          r.status = ST_FULL;
          for (int i = 0; i < TB_SLOTS; i++) begin
            if (!table_valid[i]) begin
              table_valid[i] = 1'b1;
              table_proc[i]  = pid;
              table_addr[i]  = addr;
              r.status       = ST_OK;
              r.slot_index   = SLOT_W'(i);
              break;
            end
          end
        end
      end
      FN_WAKE: begin
        lim  = (int'(cnt) > WAKE_LIMIT) ? WAKE_LIMIT : int'(cnt);
        woke = 0;
        r.status = ST_OK;
        if (addr != '0) begin
          for (int i = 0; i < TB_SLOTS && woke < lim; i++) begin
            if (table_valid[i] && table_addr[i] == addr) begin
              woke++;
              w             = '0;
              w.status      = ST_OK;
              w.slot_index  = SLOT_W'(i);
              w.has_woken   = 1'b1;
              w.woken_proc  = table_proc[i];
              w.woken_total = CNT_W'(woke);
              burst.push_back(w);
              table_valid[i] = 1'b0;
              table_proc[i]  = '0;
            end
          end
        end
      end
      FN_DROP: begin
        r.status = ST_OK;
        if (pid != '0) begin
          for (int i = 0; i < TB_SLOTS; i++) begin
            if (table_valid[i] && table_proc[i] == pid) begin
              table_valid[i] = 1'b0;
              table_proc[i]  = '0;
            end
          end
        end
      end
      default: r.status = ST_INVAL;
    endcase
    // mark the final woken beat, or fall back to the single status beat
    if (burst.size() > 0) begin
      w      = burst.pop_back();
      w.last = 1'b1;
      burst.push_back(w);
      foreach (burst[k]) pending_results.push_back(burst[k]);
    end else begin
      pending_results.push_back(r);
    end
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom()), 32'($urandom())};
  endfunction

  // Offer one request beat, with an optional idle gap, and predict on acceptance
  task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [PROC_W-1:0] pid,
                               input logic [ADDR_W-1:0] addr, input logic [CNT_W-1:0] cnt);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 14) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= fn;
    in_proc_id      <= pid;
    in_wait_address <= addr;
    in_wake_count   <= cnt;
    do @(posedge clk); while (in_stall);
    apply_table_op(fn, pid, addr, cnt);
  endtask

  // Stop sending and let every predicted beat come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic compare_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    res_t want;
    if (pending_results.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, actual status %0d slot %0d",
               $time, out_status, out_slot_index);
      errors++;
    end else begin
      want = pending_results.pop_front();
      compare_field("status",      want.status,      out_status);
      compare_field("slot_index",  want.slot_index,  out_slot_index);
      compare_field("has_woken",   want.has_woken,   out_has_woken);
      compare_field("woken_proc",  want.woken_proc,  out_woken_proc);
      compare_field("woken_total", want.woken_total, out_woken_total);
      compare_field("last",        want.last,        out_last);
    end
  endtask

  // Check each accepted result beat, then choose the next stall value
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 14);
      end
    end
  end

  // Abort when no beat moves on either channel for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // Argument checks, empty wakes, partial wakes, drops and the unknown operation
  task automatic test_argument_cases();
    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    addr_a = 48'h0000_0000_0001;
    addr_b = 48'h8000_0000_0000;
    issue_request(FN_WAIT,  8'd0,   addr_a,   7'd0);
    issue_request(FN_WAIT,  8'd5,   '0,       7'd0);
    issue_request(FN_UNDEF, 8'hFF,  ADDR_TOP, 7'h7F);
    issue_request(FN_WAKE,  8'd0,   addr_a,   7'd3);
    issue_request(FN_WAIT,  8'hFF,  ADDR_TOP, 7'h7F);
    issue_request(FN_WAIT,  8'd1,   addr_a,   7'd0);
    issue_request(FN_WAIT,  8'd2,   addr_a,   7'd0);
    issue_request(FN_WAIT,  8'd3,   addr_a,   7'd0);
    issue_request(FN_WAIT,  8'd1,   addr_b,   7'd0);
    issue_request(FN_WAKE,  8'd0,   addr_a,   7'd0);
    issue_request(FN_WAKE,  8'd0,   '0,       7'd64);
    issue_request(FN_WAKE,  8'd0,   48'h1234, 7'd5);
    issue_request(FN_WAKE,  8'd0,   addr_a,   7'd1);
    issue_request(FN_DROP,  8'd0,   addr_a,   7'd0);
    issue_request(FN_DROP,  8'd2,   '0,       7'd0);
    issue_request(FN_WAKE,  8'hAA,  addr_a,   7'h7F);
    issue_request(FN_WAIT,  8'd4,   addr_a,   7'd0);
    issue_request(FN_DROP,  8'hFF,  ADDR_TOP, 7'h7F);
    issue_request(FN_WAKE,  8'd0,   ADDR_TOP, 7'd1);
    issue_request(FN_DROP,  8'd1,   '0,       7'd0);
    issue_request(FN_DROP,  8'd4,   '0,       7'd0);
    issue_request(FN_DROP,  8'h80,  addr_b,   7'd0);
    wait_for_results();
  endtask

  // Fill every slot behind a long output hold, overflow, then wake them all at once
  task automatic test_table_full();
    logic [ADDR_W-1:0] addr_q;
    addr_q = rand_addr() | 48'h1;
    for (int i = 0; i < TB_SLOTS; i++) begin
      if (table_valid[i]) issue_request(FN_DROP, table_proc[i], '0, 7'd0);
    end
    wait_for_results();
    hold_req = HOLD_CYCLES;
    for (int i = 0; i < TB_SLOTS; i++) begin
      issue_request(FN_WAIT, 8'($urandom_range(1, 255)), addr_q, 7'($urandom()));
    end
    issue_request(FN_WAIT, 8'd7, addr_q, 7'd0);
    issue_request(FN_WAIT, 8'd0, addr_q, 7'd0);
    issue_request(FN_WAKE, 8'd0, addr_q, 7'd100);
    wait_for_results();
  endtask

  // Random waits, wakes and drops over a few shared addresses and processes
  task automatic test_mixed_traffic();
    logic [ADDR_W-1:0] addr_pool [4];
    logic [PROC_W-1:0] pid;
    logic [ADDR_W-1:0] addr;
    int                pick;
    addr_pool[0] = ADDR_TOP;
    for (int i = 1; i < 4; i++) addr_pool[i] = rand_addr() | 48'h1;
    for (int n = 0; n < 32; n++) begin
      // hold a stretch with no idling on either side
      calm = (n >= 6 && n < 26);
      pick = $urandom_range(0, 99);
      pid  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                         : 8'($urandom_range(1, 8));
      addr = addr_pool[$urandom_range(0, 3)];
      if (pick < 42) begin
        issue_request(FN_WAIT, pid, addr, 7'($urandom()));
      end else if (pick < 66) begin
        issue_request(FN_WAKE, pid, addr, ($urandom_range(0, 4) == 0)
                      ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 4)));
      end else if (pick < 78) begin
        issue_request(FN_DROP, pid, rand_addr(), 7'($urandom()));
      end else if (pick < 84) begin
        issue_request(FN_UNDEF, 8'($urandom()), rand_addr(), 7'($urandom()));
      end else if (pick < 90) begin
        issue_request(FN_WAIT, ($urandom_range(0, 1) == 0) ? 8'd0 : pid,
                      ($urandom_range(0, 1) == 0) ? '0 : rand_addr(), 7'($urandom()));
      end else begin
        issue_request(2'($urandom()), 8'($urandom()), rand_addr(), 7'($urandom()));
      end
    end
    calm = 1'b0;
    wait_for_results();
  endtask

  initial begin
    for (int i = 0; i < TB_SLOTS; i++) begin
      table_valid[i] = 1'b0;
      table_proc[i]  = '0;
      table_addr[i]  = '0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_argument_cases();
    test_table_full();
    test_mixed_traffic();
    // let any stray beat show up before judging
    repeat (TB_SLOTS + 8) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
